FILE: src/rbd_pkg.sv
// Shared constants, payload types and helper functions for the RGB565 box downscaler.
package rbd_pkg;

  // Field widths
  localparam int PIXEL_W = 16;
  localparam int SIZE_W  = 10;
  localparam int SUM_W   = 19;
  localparam int ROW_W   = 9;

  // Frame geometry
  localparam int MAX_SOURCE_HEIGHT = 512;
  localparam int WIDE_LIMIT        = 256;
  localparam int TALL_LIMIT        = 239;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SOURCE_WIDTH = 512;
  localparam int DEF_LINE_STORE_DEPTH = 256;

  // Queue depths (powers of two)
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Configuration register map
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_FULL_RES = 2'd2;

  localparam logic [SIZE_W-1:0] RST_SOURCE_WIDTH  = 10'd256;
  localparam logic [SIZE_W-1:0] RST_SOURCE_HEIGHT = 10'd224;

  // Line operation kinds
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] source_pixel;
    logic               frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] blue_byte;
    logic [7:0] green_byte;
    logic [7:0] red_byte;
    logic       frame_done;
  } pixel_out_t;

  // Classified item handed from front to back (store address travels beside it)
  typedef struct packed {
    logic             kind;
    logic             in_range;
    logic             use_prior;
    logic [1:0]       shift;
    logic             frame_done;
    logic [SUM_W-1:0] hsum;
  } line_op_t;

  // Packed sum layout: red 18:13, green 12:6, blue 5:0
  function automatic logic [SUM_W-1:0] pack_sum(input logic [PIXEL_W-1:0] px);
    pack_sum = {1'b0, px[15:11], 1'b0, px[10:5], 1'b0, px[4:0]};
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

endpackage

FILE: src/rbd_fifo.sv
// Small register-based first-in first-out queue with fill level.
module rbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (level == LVL_W'(DEPTH));
  assign empty   = (level == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

FILE: src/rbd_front.sv
// Front end: configuration registers, raster position tracking and item classification.
module rbd_front #(
  parameter int MAX_SOURCE_WIDTH = rbd_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int LINE_STORE_DEPTH = rbd_pkg::DEF_LINE_STORE_DEPTH,
  parameter int LS_AW            = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::SIZE_W-1:0]       cfg_data,
  // source items
  input  logic                             accept,
  input  rbd_pkg::pixel_in_t               source,
  // classified operations
  output logic                             op_push,
  output rbd_pkg::line_op_t                op,
  output logic [LS_AW-1:0]                 op_addr
);

  localparam int SIZE_W = rbd_pkg::SIZE_W;
  localparam int ROW_W  = rbd_pkg::ROW_W;
  localparam int SUM_W  = rbd_pkg::SUM_W;
  localparam int COL_W  = $clog2(MAX_SOURCE_WIDTH);
  localparam int WC_W   = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int SZ_W   = (WC_W > SIZE_W) ? WC_W : SIZE_W;

  // Configuration registers
  logic [SIZE_W-1:0] source_width;
  logic [SIZE_W-1:0] source_height;
  logic              keep_full_resolution;

  // Position state
  logic [COL_W-1:0]  column_position;
  logic [ROW_W-1:0]  row_position;
  logic [SUM_W-1:0]  pair_sum;

  logic [SZ_W-1:0]   sw_ext;
  logic [SZ_W-1:0]   wc;
  logic [SZ_W-1:0]   tw;
  logic [SIZE_W-1:0] hc;
  logic [SIZE_W-1:0] th;
  logic              hx;
  logic              hy;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [SUM_W-1:0]  pair_cur;
  logic [SUM_W-1:0]  cur;
  logic [SUM_W-1:0]  hsum;
  logic [SZ_W-1:0]   xo;
  logic [SIZE_W-1:0] yo;
  logic              valid_x;
  logic              first_row;
  logic              in_range;
  logic              is_store;
  logic              is_emit;
  logic [SZ_W:0]     col_inc;
  logic [SIZE_W:0]   row_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width         <= rbd_pkg::RST_SOURCE_WIDTH;
      source_height        <= rbd_pkg::RST_SOURCE_HEIGHT;
      keep_full_resolution <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rbd_pkg::REG_SOURCE_WIDTH:  source_width         <= cfg_data;
        rbd_pkg::REG_SOURCE_HEIGHT: source_height        <= cfg_data;
        rbd_pkg::REG_KEEP_FULL_RES: keep_full_resolution <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective frame size and scale decisions
  always_comb begin
    sw_ext = SZ_W'(source_width);
    if (sw_ext == '0) begin
      wc = SZ_W'(1);
    end else if (sw_ext > SZ_W'(MAX_SOURCE_WIDTH)) begin
      wc = SZ_W'(MAX_SOURCE_WIDTH);
    end else begin
      wc = sw_ext;
    end
    if (source_height == '0) begin
      hc = SIZE_W'(1);
    end else if (source_height > SIZE_W'(rbd_pkg::MAX_SOURCE_HEIGHT)) begin
      hc = SIZE_W'(rbd_pkg::MAX_SOURCE_HEIGHT);
    end else begin
      hc = source_height;
    end
    hx = !keep_full_resolution && (wc > SZ_W'(rbd_pkg::WIDE_LIMIT));
    hy = !keep_full_resolution && (hc > SIZE_W'(rbd_pkg::TALL_LIMIT));
    tw = hx ? (wc >> 1) : wc;
    th = hy ? (hc >> 1) : hc;
  end

  // Classify the offered item
  always_comb begin
    col      = source.frame_start ? '0 : column_position;
    row      = source.frame_start ? '0 : row_position;
    pair_cur = source.frame_start ? '0 : pair_sum;
    cur      = rbd_pkg::pack_sum(source.source_pixel);
    // fields never carry, so one wide add sums all three channels
    hsum     = hx ? (pair_cur + cur) : cur;
    xo       = hx ? SZ_W'(col >> 1) : SZ_W'(col);
    yo       = hy ? SIZE_W'(row >> 1) : SIZE_W'(row);
    valid_x  = (!hx || col[0]) && (xo < tw);
    first_row = hy && !row[0];
    in_range = (32'(xo) < 32'(LINE_STORE_DEPTH));
    is_store = valid_x && first_row && in_range;
    is_emit  = valid_x && !first_row && (yo < th);
    col_inc  = (SZ_W + 1)'(col) + 1'b1;
    row_inc  = (SIZE_W + 1)'(row) + 1'b1;
  end

  assign op_push       = accept && (is_store || is_emit);
  assign op.kind       = is_emit ? rbd_pkg::OP_EMIT : rbd_pkg::OP_STORE;
  assign op.in_range   = in_range;
  assign op.use_prior  = hy;
  assign op.shift      = {1'b0, hx} + {1'b0, hy};
  assign op.frame_done = (xo == tw - 1'b1) && (yo == th - 1'b1);
  assign op.hsum       = hsum;
  assign op_addr       = LS_AW'(xo);

  // Position update on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      pair_sum        <= '0;
    end else if (accept) begin
      if (hx && !col[0]) begin
        pair_sum <= cur;
      end else begin
        pair_sum <= pair_cur;
      end
      if (col_inc >= {1'b0, wc}) begin
        column_position <= '0;
        row_position    <= (row_inc >= {1'b0, hc}) ? '0 : ROW_W'(row_inc);
      end else begin
        column_position <= COL_W'(col_inc);
        row_position    <= row;
      end
    end
  end

endmodule

FILE: src/rbd_back.sv
// Back end: line store access, vertical sum, averaging and widening to eight bits.
module rbd_back #(
  parameter int LINE_STORE_DEPTH = rbd_pkg::DEF_LINE_STORE_DEPTH,
  parameter int LS_AW            = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // classified operations
  input  logic                                   op_empty,
  input  rbd_pkg::line_op_t                      op,
  input  logic [LS_AW-1:0]                       op_addr,
  output logic                                   op_pop,
  // result queue
  input  logic [$clog2(rbd_pkg::OUT_DEPTH+1)-1:0] out_level,
  output logic                                   out_push,
  output rbd_pkg::pixel_out_t                    out_item
);

  localparam int SUM_W = rbd_pkg::SUM_W;
  localparam int LVL_W = $clog2(rbd_pkg::OUT_DEPTH + 1);

  logic [SUM_W-1:0] line_store [LINE_STORE_DEPTH];

  logic             s1_valid;
  logic [SUM_W-1:0] s1_hsum;
  logic             s1_use_mem;
  logic [1:0]       s1_shift;
  logic             s1_frame_done;
  logic [SUM_W-1:0] rd_data;

  logic [SUM_W-1:0] prior;
  logic [6:0]       rs;
  logic [7:0]       gs;
  logic [6:0]       bs;
  logic [LVL_W:0]   committed;

  // Issue only while the result queue has room for everything in flight
  assign committed = (LVL_W + 1)'(out_level) + (LVL_W + 1)'(s1_valid);
  assign op_pop    = !op_empty && (committed < (LVL_W + 1)'(rbd_pkg::OUT_DEPTH));

  // Line store: one write or one read per item
  always_ff @(posedge clk) begin
    if (op_pop && op.in_range) begin
      if (op.kind == rbd_pkg::OP_STORE) begin
        line_store[op_addr] <= op.hsum;
      end else if (op.use_prior) begin
        rd_data <= line_store[op_addr];
      end
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= op_pop && (op.kind == rbd_pkg::OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      s1_hsum       <= op.hsum;
      s1_use_mem    <= op.use_prior && op.in_range;
      s1_shift      <= op.shift;
      s1_frame_done <= op.frame_done;
    end
  end

  // Vertical sum, mean and widening
  always_comb begin
    prior = s1_use_mem ? rd_data : '0;
    rs    = {1'b0, s1_hsum[18:13]} + {1'b0, prior[18:13]};
    gs    = {1'b0, s1_hsum[12:6]}  + {1'b0, prior[12:6]};
    bs    = {1'b0, s1_hsum[5:0]}   + {1'b0, prior[5:0]};
    out_item.blue_byte  = rbd_pkg::widen5(5'(bs >> s1_shift));
    out_item.green_byte = rbd_pkg::widen6(6'(gs >> s1_shift));
    out_item.red_byte   = rbd_pkg::widen5(5'(rs >> s1_shift));
    out_item.frame_done = s1_frame_done;
  end

  assign out_push = s1_valid;

endmodule

FILE: src/rgb565_box_downscale_to_bgr888.sv
// Top level of the RGB565 to BGR888 converter with box downscaling by up to 2x2.
//
// Source pixels arrive in raster order on a queue-style input: an item is
// taken at a clock edge where push is high and full is low. Results leave
// through a queue-style output: the oldest result sits on result while
// empty is low and is taken at an edge where pop is high.
// Geometry registers are written on the cfg channel (always ready); index 0
// is source_width, 1 source_height, 2 keep_full_resolution.
// Throughput: one source pixel per clock while the receiver keeps up. The
// front end classifies each pixel in the cycle it is taken; the back end
// makes one line store access per item, so both run at one item a cycle
// until the result queue fills. The pixel that completes a result passes
// through the operation queue, back end stage 1 and the result queue.
// When the receiver stalls, results collect in a four-entry output queue,
// then the four-entry operation queue fills and full rises.
// Reset clears position, queues and registers to their defaults; the line
// store needs no clearing, each entry is written before it is read.
module rgb565_box_downscale_to_bgr888 #(
  parameter int MAX_SOURCE_WIDTH = rbd_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int LINE_STORE_DEPTH = rbd_pkg::DEF_LINE_STORE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rbd_pkg::SIZE_W-1:0]      cfg_data,
  // source pixels
  input  logic                            push,
  output logic                            full,
  input  rbd_pkg::pixel_in_t              source,
  // result pixels
  output logic                            empty,
  input  logic                            pop,
  output rbd_pkg::pixel_out_t             result
);

  localparam int LS_AW  = (LINE_STORE_DEPTH > 1) ? $clog2(LINE_STORE_DEPTH) : 1;
  localparam int OP_W   = $bits(rbd_pkg::line_op_t);
  localparam int MQ_W   = OP_W + LS_AW;
  localparam int OUT_W  = $bits(rbd_pkg::pixel_out_t);
  localparam int MLVL_W = $clog2(rbd_pkg::MID_DEPTH + 1);
  localparam int OLVL_W = $clog2(rbd_pkg::OUT_DEPTH + 1);

  logic                 accept;
  logic                 op_push;
  rbd_pkg::line_op_t    op_in;
  logic [LS_AW-1:0]     addr_in;
  logic [MQ_W-1:0]      mq_head;
  logic                 mq_empty;
  logic                 mq_pop;
  logic [MLVL_W-1:0]    mq_level;
  rbd_pkg::line_op_t    op_out;
  logic [LS_AW-1:0]     addr_out;
  logic                 out_push;
  rbd_pkg::pixel_out_t  out_item;
  logic [OLVL_W-1:0]    out_level;
  logic                 out_full;

  assign accept = push && !full;

  rbd_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .LINE_STORE_DEPTH (LINE_STORE_DEPTH),
    .LS_AW            (LS_AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .source    (source),
    .op_push   (op_push),
    .op        (op_in),
    .op_addr   (addr_in)
  );

  // Operation queue between front and back
  rbd_fifo #(
    .WIDTH (MQ_W),
    .DEPTH (rbd_pkg::MID_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .wdata ({op_in, addr_in}),
    .full  (full),
    .pop   (mq_pop),
    .rdata (mq_head),
    .empty (mq_empty),
    .level (mq_level)
  );

  assign op_out   = rbd_pkg::line_op_t'(mq_head[MQ_W-1:LS_AW]);
  assign addr_out = mq_head[LS_AW-1:0];

  rbd_back #(
    .LINE_STORE_DEPTH (LINE_STORE_DEPTH),
    .LS_AW            (LS_AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_empty  (mq_empty || (mq_level == '0)),
    .op        (op_out),
    .op_addr   (addr_out),
    .op_pop    (mq_pop),
    .out_level (out_level),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  // Result queue; the back end only issues when it has room
  rbd_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (rbd_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push && !out_full),
    .wdata (out_item),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .level (out_level)
  );

endmodule
